### rtl/swbl_pkg.sv
// ----------------------------------------------------------------------------
// swbl_pkg
// Shared types, widths and codes for the sliding-window byte limiter.
// ----------------------------------------------------------------------------
package swbl_pkg;

    localparam int LOG_DEPTH  = 64;
    localparam int PTR_W      = $clog2(LOG_DEPTH);
    localparam int CNT_W      = $clog2(LOG_DEPTH + 1);

    localparam int NOW_W      = 48;
    localparam int BYTES_W    = 32;
    localparam int WINDOW_W   = 40;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 40;

    typedef struct packed {
        logic [NOW_W-1:0]   stamp;
        logic [BYTES_W-1:0] size;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [STATUS_W-1:0] {
        STAT_ADMIT = 2'd0,
        STAT_OVER  = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BYTE_LIMIT = 1'b0,
        CFG_WINDOW     = 1'b1
    } t_cfg_index;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } t_state;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(LOG_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

endpackage

### rtl/sliding_window_byte_limiter.sv
// ----------------------------------------------------------------------------
// sliding_window_byte_limiter
// Sliding-window log byte rate limiter with a FIFO log held in one memory.
// ----------------------------------------------------------------------------
// Each request first retires the expired logged entries at the head, then
// decides: the log memory reads the head entry into a register, and the
// expiry loop retires one entry per cycle while reading the next head. One
// request is in flight at a time; the next one is taken
// as soon as the current result is loaded into the output register, even if
// that result is still waiting downstream. A result is loaded only when the
// output register is free or being drained. A window of zero admits with no
// log access. Configuration writes are always ready and should be issued
// only while no request is in flight.
module sliding_window_byte_limiter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [swbl_pkg::NOW_W-1:0]      i_now_us,
    input  logic [swbl_pkg::BYTES_W-1:0]    i_byte_count,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [swbl_pkg::STATUS_W-1:0]   o_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [swbl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [swbl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import swbl_pkg::*;

    t_state               r_state, n_state;
    logic [NOW_W-1:0]     r_now;
    logic [BYTES_W-1:0]   r_bytes;
    logic [BYTES_W-1:0]   r_limit;
    logic [WINDOW_W-1:0]  r_window;
    logic [PTR_W-1:0]     r_head, n_head;
    logic [PTR_W-1:0]     r_tail, n_tail;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [BYTES_W-1:0]   r_total, n_total;
    logic                 r_out_valid, n_out_valid;
    t_status              r_status, n_status;

    logic                 in_take;
    logic                 out_free;
    logic                 pop;
    logic                 decide;
    logic                 wr_en;
    logic                 too_old;
    logic                 over;
    logic                 full;
    logic [NOW_W-1:0]     age;
    logic [BYTES_W:0]     sum;
    logic [ENTRY_W-1:0]   rd_data;
    t_entry               head_entry;
    t_entry               wr_entry;

    // memory read address follows the next head so read data is always current
    swbl_log_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LOG_DEPTH)
    ) u_log_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (wr_entry),
        .i_rd_addr (n_head),
        .o_rd_data (rd_data)
    );

    assign head_entry     = t_entry'(rd_data);
    assign wr_entry.stamp = r_now;
    assign wr_entry.size  = r_bytes;

    // expiry test and admission checks
    always_comb begin
        age     = r_now - head_entry.stamp;
        too_old = (r_now > head_entry.stamp) && (age > NOW_W'(r_window));
        sum     = {1'b0, r_total} + {1'b0, r_bytes};
        over    = sum > {1'b0, r_limit};
        full    = r_count == CNT_W'(LOG_DEPTH);
    end

    // control outputs
    always_comb begin
        o_in_stall = r_state != ST_IDLE;
        in_take    = i_in_valid && (r_state == ST_IDLE);
        out_free   = !r_out_valid || !i_out_stall;
        pop        = 1'b0;
        decide     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                pop    = 1'b0;
                decide = 1'b0;
            end
            ST_EVAL: begin
                pop    = (r_window != '0) && (r_count != '0) && too_old;
                decide = !pop && out_free;
            end
            default: begin
                pop    = 1'b0;
                decide = 1'b0;
            end
        endcase
        wr_en = decide && (r_window != '0) && !over && !full;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (decide) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // log pointers, count and running total
    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        n_total = r_total;
        if (pop) begin
            n_head  = ptr_inc(r_head);
            n_count = r_count - 1'b1;
            n_total = r_total - head_entry.size;
        end else if (wr_en) begin
            n_tail  = ptr_inc(r_tail);
            n_count = r_count + 1'b1;
            n_total = sum[BYTES_W-1:0];
        end
    end

    // result
    always_comb begin
        n_out_valid = decide || (r_out_valid && i_out_stall);
        n_status    = r_status;
        if (decide) begin
            if (r_window == '0) begin
                n_status = STAT_ADMIT;
            end else if (over) begin
                n_status = STAT_OVER;
            end else if (full) begin
                n_status = STAT_FULL;
            end else begin
                n_status = STAT_ADMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now   <= i_now_us;
            r_bytes <= i_byte_count;
        end
        r_status <= n_status;
    end

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= '0;
            r_window <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_BYTE_LIMIT: r_limit  <= i_cfg_data[BYTES_W-1:0];
                CFG_WINDOW:     r_window <= i_cfg_data[WINDOW_W-1:0];
                default: begin
                    r_limit <= r_limit;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

endmodule

### rtl/swbl_log_ram.sv
// ----------------------------------------------------------------------------
// swbl_log_ram
// Simple dual-port log memory: one write port and one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module swbl_log_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
